/* hw/rtl/sqcp_pkg.sv */
// ----------------------------------------------------------------------------
// Serial query command parser package
// Shared types, marks, command words and the identification reply text.
// ----------------------------------------------------------------------------
package sqcp_pkg;

  // Framing marks and line endings.
  localparam logic [7:0] MARK_START = 8'h2A;
  localparam logic [7:0] MARK_END   = 8'h3F;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  // Command words, first character first.
  localparam logic [7:0] IDN_0  = 8'h49;
  localparam logic [7:0] IDN_1  = 8'h44;
  localparam logic [7:0] IDN_2  = 8'h4E;
  localparam logic [7:0] TEMP_0 = 8'h54;
  localparam logic [7:0] TEMP_1 = 8'h45;
  localparam logic [7:0] TEMP_2 = 8'h4D;
  localparam logic [7:0] TEMP_3 = 8'h50;

  // Number of payload bytes kept for the word compare.
  localparam int HEAD_LEN = 4;

  // Reply lengths and the byte index width.
  localparam int IDENT_LEN = 34;
  localparam int TEMP_LEN  = 4;
  localparam int IDX_W     = 6;

  // Reply kinds.
  localparam logic REPLY_IDN  = 1'b0;
  localparam logic REPLY_TEMP = 1'b1;

  // Reply request passed from the parser to the reply generator.
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] temp_first;
    logic [7:0] temp_second;
  } reply_req_t;

  // One character of the identification string.
  function automatic logic [7:0] ident_char(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      6'd0:    c = "T";
      6'd1:    c = "h";
      6'd2:    c = "e";
      6'd3:    c = "r";
      6'd4:    c = "m";
      6'd5:    c = "o";
      6'd6:    c = "c";
      6'd7:    c = "o";
      6'd8:    c = "u";
      6'd9:    c = "p";
      6'd10:   c = "l";
      6'd11:   c = "e";
      6'd12:   c = ",";
      6'd13:   c = "S";
      6'd14:   c = "T";
      6'd15:   c = "M";
      6'd16:   c = "3";
      6'd17:   c = "2";
      6'd18:   c = "F";
      6'd19:   c = "1";
      6'd20:   c = ",";
      6'd21:   c = "s";
      6'd22:   c = "/";
      6'd23:   c = "n";
      6'd24:   c = "1";
      6'd25:   c = ",";
      6'd26:   c = "v";
      6'd27:   c = "e";
      6'd28:   c = "r";
      6'd29:   c = "1";
      6'd30:   c = ".";
      6'd31:   c = "0";
      6'd32:   c = CHAR_CR;
      6'd33:   c = CHAR_LF;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/sqcp_parser.sv */
// ----------------------------------------------------------------------------
// Serial query command parser: frame parser
// Tracks the start and end marks, keeps the payload count and the leading
// payload bytes, and raises a reply request on a matching end mark.
// ----------------------------------------------------------------------------
module sqcp_parser #(
  parameter int PAYLOAD_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          temp_first_byte,
  input  logic [7:0]          temp_second_byte,
  input  logic                req_take,
  output sqcp_pkg::reply_req_t req
);

  localparam int CNT_W = $clog2(PAYLOAD_DEPTH);

  logic             in_cmd_r, in_cmd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       head_r [sqcp_pkg::HEAD_LEN];
  logic             req_vld_r, req_vld_nxt;
  logic             req_kind_r;
  logic [7:0]       req_t0_r;
  logic [7:0]       req_t1_r;

  logic        accept;
  logic [31:0] cnt_ext;
  logic        head_wr;
  logic        is_idn;
  logic        is_temp;

  // A pending request blocks input until the reply generator takes it.
  assign in_tready = !req_vld_r || req_take;
  assign accept    = in_tvalid && in_tready;
  assign cnt_ext   = 32'(cnt_r);
  assign head_wr   = cnt_ext < 32'(sqcp_pkg::HEAD_LEN);

  // Word compare on the stored payload.
  assign is_idn  = (cnt_ext == 32'd3) &&
                   (head_r[0] == sqcp_pkg::IDN_0) &&
                   (head_r[1] == sqcp_pkg::IDN_1) &&
                   (head_r[2] == sqcp_pkg::IDN_2);
  assign is_temp = (cnt_ext == 32'd4) &&
                   (head_r[0] == sqcp_pkg::TEMP_0) &&
                   (head_r[1] == sqcp_pkg::TEMP_1) &&
                   (head_r[2] == sqcp_pkg::TEMP_2) &&
                   (head_r[3] == sqcp_pkg::TEMP_3);

  // Next-state logic for the frame tracker and the request flag.
  always_comb begin
    in_cmd_nxt  = in_cmd_r;
    cnt_nxt     = cnt_r;
    req_vld_nxt = req_vld_r && !req_take;
    if (accept) begin
      if (!in_cmd_r) begin
        if (rx_byte == sqcp_pkg::MARK_START) begin
          in_cmd_nxt = 1'b1;
        end
      end else if (rx_byte == sqcp_pkg::MARK_END) begin
        in_cmd_nxt  = 1'b0;
        cnt_nxt     = '0;
        req_vld_nxt = is_idn || is_temp;
      end else if (cnt_r == CNT_W'(PAYLOAD_DEPTH - 1)) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cmd_r  <= 1'b0;
      cnt_r     <= '0;
      req_vld_r <= 1'b0;
    end else begin
      in_cmd_r  <= in_cmd_nxt;
      cnt_r     <= cnt_nxt;
      req_vld_r <= req_vld_nxt;
    end
  end

  // Leading payload bytes; the payload count wraps, so bytes after the wrap overwrite them.
  always_ff @(posedge clk) begin
    if (accept && in_cmd_r && rx_byte != sqcp_pkg::MARK_END && head_wr) begin
      head_r[cnt_r[1:0]] <= rx_byte;
    end
  end

  // Request payload, captured on the end mark.
  always_ff @(posedge clk) begin
    if (accept && in_cmd_r && rx_byte == sqcp_pkg::MARK_END) begin
      req_kind_r <= is_temp ? sqcp_pkg::REPLY_TEMP : sqcp_pkg::REPLY_IDN;
      req_t0_r   <= temp_first_byte;
      req_t1_r   <= temp_second_byte;
    end
  end

  assign req = '{valid: req_vld_r, kind: req_kind_r,
                 temp_first: req_t0_r, temp_second: req_t1_r};

endmodule

/* hw/rtl/sqcp_reply.sv */
// ----------------------------------------------------------------------------
// Serial query command parser: reply generator
// Steps through the bytes of one reply and loads them into the output
// register, one byte per transfer.
// ----------------------------------------------------------------------------
module sqcp_reply (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sqcp_pkg::reply_req_t req,
  output logic                 req_take,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);

  logic                       busy_r, busy_nxt;
  logic                       kind_r;
  logic [7:0]                 t0_r;
  logic [7:0]                 t1_r;
  logic [sqcp_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       ovld_r, ovld_nxt;
  logic [7:0]                 odata_r;
  logic                       olast_r;

  logic       load;
  logic [7:0] byte_sel;
  logic       last_sel;

  // A new reply starts only once the previous one has been fully loaded.
  assign req_take = !busy_r;
  assign load     = busy_r && (!ovld_r || out_tready);

  // Byte and end flag for the current index.
  always_comb begin
    if (kind_r == sqcp_pkg::REPLY_TEMP) begin
      unique case (idx_r[1:0])
        2'd0:    byte_sel = t0_r;
        2'd1:    byte_sel = t1_r;
        2'd2:    byte_sel = sqcp_pkg::CHAR_CR;
        default: byte_sel = sqcp_pkg::CHAR_LF;
      endcase
      last_sel = idx_r == sqcp_pkg::IDX_W'(sqcp_pkg::TEMP_LEN - 1);
    end else begin
      byte_sel = sqcp_pkg::ident_char(idx_r);
      last_sel = idx_r == sqcp_pkg::IDX_W'(sqcp_pkg::IDENT_LEN - 1);
    end
  end

  // Sequencer and output valid.
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ovld_nxt = ovld_r && !out_tready;
    if (load) begin
      ovld_nxt = 1'b1;
      idx_nxt  = idx_r + 1'b1;
      if (last_sel) begin
        busy_nxt = 1'b0;
      end
    end else if (req_take && req.valid) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  // Reply parameters, held for the whole reply.
  always_ff @(posedge clk) begin
    if (req_take && req.valid) begin
      kind_r <= req.kind;
      t0_r   <= req.temp_first;
      t1_r   <= req.temp_second;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load) begin
      odata_r <= byte_sel;
      olast_r <= last_sel;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

endmodule

/* hw/rtl/serial_query_command_parser_top.sv */
// ----------------------------------------------------------------------------
// Serial query command parser
// Parses '*'...'?' framed queries from a byte stream and answers IDN and
// TEMP with reply byte streams.
// ----------------------------------------------------------------------------
//  Channel | Ports  | Contents
//  input   | in_*   | tdata[7:0] rx_byte, [15:8] temp_first_byte,
//          |        | [23:16] temp_second_byte
//  result  | out_*  | tdata[7:0] tx_byte, tlast last_of_reply
//
//  Input bytes are taken one per cycle; bytes other than a matching end
//  mark cause no result. A matching end mark starts a reply that leaves
//  the output register at one byte per cycle (34 for IDN, 4 for TEMP),
//  set by the reply sequencer. One further query may be taken and held
//  while a reply runs; input then stalls until that reply is loaded.
//  Reset is synchronous and active low; no clearing pass. Output stalls
//  hold the reply byte and back-pressure the sequencer.
// ----------------------------------------------------------------------------
module serial_query_command_parser_top #(
  parameter int PAYLOAD_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // rx_byte, temp_first_byte, temp_second_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // tx_byte
  output logic        out_tlast
);

  sqcp_pkg::reply_req_t req;
  logic                 req_take;

  // Frame parsing and word compare.
  sqcp_parser #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .rx_byte          (in_tdata[7:0]),
    .temp_first_byte  (in_tdata[15:8]),
    .temp_second_byte (in_tdata[23:16]),
    .req_take         (req_take),
    .req              (req)
  );

  // Reply sequencing and output register.
  sqcp_reply u_reply (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .req_take   (req_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* hw/rtl/sqcp_checker.sv */
// ----------------------------------------------------------------------------
// Serial query command parser checker
// Port-level checks on reset, flow control and reply framing.
// ----------------------------------------------------------------------------
module sqcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  // No reply byte is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result transfer holds its byte and end flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Every reply ends with a line feed.
  a_last_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == sqcp_pkg::CHAR_LF)
    else $error("reply does not end with LF");

  // Only an end mark can stop the input from flowing.
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[7:0] != sqcp_pkg::MARK_END |=> in_tready)
    else $error("input stalled after an ordinary byte");

endmodule

bind serial_query_command_parser_top sqcp_checker u_sqcp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
